// ===== src/tfb_pkg.sv =====
package tfb_pkg;

	// Sizing
	localparam int MAX_WINDOW  = 10;
	localparam int FRAME_BYTES = 65536;
	localparam int SLOTS       = MAX_WINDOW - 1;
	localparam int POS_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HIST_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
	localparam int RANK_W      = $clog2(MAX_WINDOW);
	localparam int SUM_W       = $clog2(MAX_WINDOW * 255 + 1);
	localparam int RCP_W       = 17;
	localparam int RCP_SHIFT   = 16;
	localparam int ADDR_W      = 4;

	// Register indexes
	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	// Blend modes
	localparam logic [1:0] MODE_MEAN   = 2'd0;
	localparam logic [1:0] MODE_MEDIAN = 2'd1;
	localparam logic [1:0] MODE_MAX    = 2'd2;
	localparam logic [1:0] MODE_MIN    = 2'd3;

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       frame_end;
	} in_data_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_end_out;
	} out_data_t;

	typedef struct packed {
		logic [3:0] window_length;
		logic [1:0] blend_mode;
		logic       filter_enable;
	} cfg_t;

	// One classified request between front and back
	typedef struct packed {
		logic [7:0]        pixel;
		logic              last;
		logic [POS_W-1:0]  pos;
		logic [HIST_W-1:0] hist;
		logic [SLOT_W-1:0] newest;
		logic [SLOT_W-1:0] wslot;
		logic [1:0]        mode;
		logic              enable;
	} entry_t;

	// floor(2^16 / n) for frame counts up to 16
	function automatic logic [RCP_W-1:0] recip(input logic [4:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			5'd1:    r = 17'd65536;
			5'd2:    r = 17'd32768;
			5'd3:    r = 17'd21845;
			5'd4:    r = 17'd16384;
			5'd5:    r = 17'd13107;
			5'd6:    r = 17'd10922;
			5'd7:    r = 17'd9362;
			5'd8:    r = 17'd8192;
			5'd9:    r = 17'd7281;
			5'd10:   r = 17'd6553;
			5'd11:   r = 17'd5957;
			5'd12:   r = 17'd5461;
			5'd13:   r = 17'd5041;
			5'd14:   r = 17'd4681;
			5'd15:   r = 17'd4369;
			5'd16:   r = 17'd4096;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

// ===== src/tfb_front.sv =====
module tfb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tfb_pkg::in_data_t in_data,
	input  tfb_pkg::cfg_t    cfg,
	input  logic             q_full,
	output logic             push,
	output tfb_pkg::entry_t  entry
);
	import tfb_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [HIST_W-1:0] hist_q;
	logic [SLOT_W-1:0] newest_q;

	logic [CNT_W-1:0]  eff;
	logic [HIST_W-1:0] keep;
	logic [HIST_W-1:0] hist_cut;
	logic [SLOT_W-1:0] wslot;
	logic              last;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Effective window and history cut at frame start
	always_comb begin
		if (cfg.window_length == 4'd0) begin
			eff = CNT_W'(1);
		end else if ({1'b0, cfg.window_length} > 5'(MAX_WINDOW)) begin
			eff = CNT_W'(MAX_WINDOW);
		end else begin
			eff = CNT_W'(cfg.window_length);
		end
		keep = HIST_W'(eff - CNT_W'(1));
		if (pos_q == '0 && hist_q > keep) begin
			hist_cut = keep;
		end else begin
			hist_cut = hist_q;
		end
		wslot = (newest_q == SLOT_W'(SLOTS - 1)) ? '0 : newest_q + SLOT_W'(1);
		last  = in_data.frame_end || (pos_q == POS_W'(FRAME_BYTES - 1));
	end

	always_comb begin
		entry.pixel  = in_data.pixel_in;
		entry.last   = last;
		entry.pos    = pos_q;
		entry.hist   = hist_cut;
		entry.newest = newest_q;
		entry.wslot  = wslot;
		entry.mode   = cfg.blend_mode;
		entry.enable = cfg.filter_enable;
	end

	// Frame position and history bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hist_q   <= '0;
			newest_q <= '0;
		end else if (push) begin
			if (last) begin
				pos_q    <= '0;
				newest_q <= wslot;
				hist_q   <= (hist_cut < HIST_W'(SLOTS)) ? hist_cut + HIST_W'(1) : hist_cut;
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				hist_q <= hist_cut;
			end
		end
	end

endmodule

// ===== src/tfb_queue.sv =====
module tfb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tfb_pkg::entry_t push_data,
	input  logic            pop,
	output tfb_pkg::entry_t head,
	output logic            full,
	output logic            empty
);
	import tfb_pkg::*;

	entry_t     slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign head  = slot_q[rd_q];
	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Two-entry pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/tfb_back.sv =====
module tfb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tfb_pkg::entry_t   head,
	input  logic              q_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output tfb_pkg::out_data_t out_data
);
	import tfb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_GATHER = 5'b00010,
		ST_RANK   = 5'b00100,
		ST_SEL    = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t state_q;

	entry_t            job_q;
	logic [7:0]        rdata_q [SLOTS];
	logic [7:0]        val_q [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] ok_q;
	logic [RANK_W-1:0] rank_q [MAX_WINDOW];
	logic [SUM_W-1:0]  sum_q;
	logic [7:0]        max_q;
	logic [7:0]        min_q;
	logic [7:0]        s_lo_q;
	logic [7:0]        s_hi_q;
	logic [SUM_W-1:0]  qest_q;
	logic              out_valid_q;
	out_data_t         out_q;

	logic [CNT_W-1:0]  n;
	logic [7:0]        lane_val [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] lane_ok;
	logic [SUM_W-1:0]  sum_c;
	logic [7:0]        max_c;
	logic [7:0]        min_c;
	logic [RANK_W-1:0] rank_c [MAX_WINDOW];
	logic [RANK_W-1:0] mid_hi;
	logic [RANK_W-1:0] mid_lo;
	logic [7:0]        s_hi_c;
	logic [7:0]        s_lo_c;
	logic [SUM_W+RCP_W-1:0] prod;
	logic [SUM_W+CNT_W-1:0] qn;
	logic [SUM_W-1:0]  rem;
	logic [SUM_W-1:0]  mean;
	logic [8:0]        mid_sum;
	logic [7:0]        blended;
	logic [7:0]        result;
	logic              mem_en;
	logic              load_out;

	assign n        = CNT_W'(job_q.hist) + CNT_W'(1);
	assign mem_en   = (state_q == ST_IDLE) && !q_empty;
	assign pop      = mem_en;
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Frame store banks: read old data and write current byte at one address
	for (genvar b = 0; b < SLOTS; b++) begin : g_bank
		logic [7:0] mem [FRAME_BYTES];
		always_ff @(posedge clk) begin
			if (mem_en) begin
				if (head.wslot == SLOT_W'(b)) begin
					mem[head.pos] <= head.pixel;
				end
				rdata_q[b] <= mem[head.pos];
			end
		end
	end

	// Lanes: earlier frames newest first, then the current byte
	always_comb begin
		logic [SLOT_W:0] sl;
		for (int k = 0; k < SLOTS; k++) begin
			if ({1'b0, job_q.newest} >= (SLOT_W+1)'(k)) begin
				sl = {1'b0, job_q.newest} - (SLOT_W+1)'(k);
			end else begin
				sl = {1'b0, job_q.newest} + (SLOT_W+1)'(SLOTS - k);
			end
			lane_val[k] = rdata_q[sl[SLOT_W-1:0]];
			lane_ok[k]  = (HIST_W'(k) < job_q.hist);
		end
		lane_val[SLOTS] = job_q.pixel;
		lane_ok[SLOTS]  = 1'b1;
	end

	// Sum, maximum and minimum over valid lanes
	always_comb begin
		sum_c = '0;
		max_c = 8'd0;
		min_c = 8'd255;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (lane_ok[i]) begin
				sum_c = sum_c + SUM_W'(lane_val[i]);
				if (lane_val[i] > max_c) max_c = lane_val[i];
				if (lane_val[i] < min_c) min_c = lane_val[i];
			end
		end
	end

	// Sorted position of each lane, ties broken by lane number
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < MAX_WINDOW; j++) begin
				if (ok_q[j] && (val_q[j] < val_q[i] || (val_q[j] == val_q[i] && j < i))) begin
					rank_c[i] = rank_c[i] + RANK_W'(1);
				end
			end
		end
	end

	// Middle values and mean estimate
	always_comb begin
		mid_hi = RANK_W'(n >> 1);
		mid_lo = mid_hi - RANK_W'(1);
		s_hi_c = 8'd0;
		s_lo_c = 8'd0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (ok_q[i] && rank_q[i] == mid_hi) s_hi_c = s_hi_c | val_q[i];
			if (ok_q[i] && rank_q[i] == mid_lo) s_lo_c = s_lo_c | val_q[i];
		end
		prod = SUM_W'(sum_q) * recip(5'(n));
	end

	// Final correction, mode select and bypass when the filter is disabled
	always_comb begin
		qn      = qest_q * n;
		rem     = sum_q - SUM_W'(qn);
		mean    = (rem >= SUM_W'(n)) ? qest_q + SUM_W'(1) : qest_q;
		mid_sum = {1'b0, s_lo_q} + {1'b0, s_hi_q} + 9'd1;
		case (job_q.mode)
			MODE_MEAN:   blended = mean[7:0];
			MODE_MEDIAN: blended = n[0] ? s_hi_q : mid_sum[8:1];
			MODE_MAX:    blended = max_q;
			MODE_MIN:    blended = min_q;
			default:     blended = mean[7:0];
		endcase
		result = job_q.enable ? blended : job_q.pixel;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (mem_en) job_q <= head;
			end
			ST_GATHER: begin
				for (int i = 0; i < MAX_WINDOW; i++) val_q[i] <= lane_val[i];
				ok_q  <= lane_ok;
				sum_q <= sum_c;
				max_q <= max_c;
				min_q <= min_c;
			end
			ST_RANK: begin
				for (int i = 0; i < MAX_WINDOW; i++) rank_q[i] <= rank_c[i];
			end
			ST_SEL: begin
				s_hi_q <= s_hi_c;
				s_lo_q <= s_lo_c;
				qest_q <= prod[RCP_SHIFT +: SUM_W];
			end
			ST_FIN: begin
				if (load_out) begin
					out_q.pixel_out     <= result;
					out_q.frame_end_out <= job_q.last;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:   if (mem_en) state_q <= ST_GATHER;
				ST_GATHER: state_q <= ST_RANK;
				ST_RANK:   state_q <= ST_SEL;
				ST_SEL:    state_q <= ST_FIN;
				ST_FIN:    if (load_out) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/temporal_frame_blend_filter_top.sv =====
// A request passes through the back end sequencer (store read, gather, rank,
// select, finish), which handles one byte at a time and holds in finish while
// the output is stalled, so it takes no new request before the last is done.
// A two-entry queue lets the input side run ahead while the back end works.
// Reset (arst_n, async, active low) clears position, history, queue, state,
// output valid and config to defaults; frame store undefined until written.
module temporal_frame_blend_filter_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tfb_pkg::in_data_t    in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tfb_pkg::out_data_t   out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [tfb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import tfb_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;
	logic   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length <= 4'd3;
			cfg_q.blend_mode    <= MODE_MEAN;
			cfg_q.filter_enable <= 1'b1;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_WINDOW: cfg_q.window_length <= pwdata[3:0];
				REG_MODE:   cfg_q.blend_mode    <= pwdata[1:0];
				REG_ENABLE: cfg_q.filter_enable <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW: prdata = {28'd0, cfg_q.window_length};
			REG_MODE:   prdata = {30'd0, cfg_q.blend_mode};
			REG_ENABLE: prdata = {31'd0, cfg_q.filter_enable};
			default:    prdata = 32'd0;
		endcase
	end

	tfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.entry    (push_entry)
	);

	tfb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	tfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty)) else $error("queue full and empty at once");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !q_full) else $error("request taken into full queue");

	a_hist_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry.hist <= HIST_W'(SLOTS))) else $error("history count out of range");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("pop from empty queue");
`endif

endmodule
